// File: hw/rtl/ctmo_pkg.sv
// ----------------------------------------------------------------------------
// ctmo_pkg
// Shared types and constants of the color threshold mask and outline block.
// ----------------------------------------------------------------------------
package ctmo_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int SIZE_W = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [2:0] {
    REG_THRESHOLD,
    REG_TARGET_RED,
    REG_TARGET_GREEN,
    REG_TARGET_BLUE,
    REG_TARGET_ALPHA,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_MASK,
    KIND_EDGE,
    KIND_SUMMARY
  } kind_t;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM,
    SIDE_LEFT
  } side_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
  } pixel_t;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic        matched;
    side_t       side;
    logic        found;
    logic [9:0]  box_x_min;
    logic [9:0]  box_y_min;
    logic [10:0] box_width;
    logic [10:0] box_height;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0]        threshold;
    logic [7:0]        target_red;
    logic [7:0]        target_green;
    logic [7:0]        target_blue;
    logic [7:0]        target_alpha;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
  } cfg_t;

  // result slots of one pixel, in delivery order
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam logic [SLOT_W-1:0] SLOT_MASK        = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_PREV_RIGHT  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_ABOVE_BOT   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_TOP         = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT       = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_BOTTOM      = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_LEFT        = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_SUMMARY     = 3'd7;

  // one classified pixel waiting to be emitted
  typedef struct packed {
    logic [9:0]           pos_x;
    logic [9:0]           pos_y;
    logic                 matched;
    logic                 found;
    logic [9:0]           box_x_min;
    logic [9:0]           box_y_min;
    logic [10:0]          box_width;
    logic [10:0]          box_height;
    logic [NUM_SLOTS-1:0] pend;
  } desc_t;

endpackage

// File: hw/rtl/ctmo_cfg.sv
// ----------------------------------------------------------------------------
// ctmo_cfg
// APB register file holding threshold, key color and image size.
// ----------------------------------------------------------------------------
module ctmo_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctmo_pkg::ADDR_W-1:0] paddr,
  input  logic [ctmo_pkg::DATA_W-1:0] pwdata,
  output logic [ctmo_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output ctmo_pkg::cfg_t              cfg
);

  ctmo_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = ctmo_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= '0;
      cfg.target_red   <= '0;
      cfg.target_green <= '0;
      cfg.target_blue  <= '0;
      cfg.target_alpha <= '0;
      cfg.image_width  <= ctmo_pkg::SIZE_RESET;
      cfg.image_height <= ctmo_pkg::SIZE_RESET;
    end else if (wr) begin
      case (idx)
        ctmo_pkg::REG_THRESHOLD:    cfg.threshold    <= pwdata[7:0];
        ctmo_pkg::REG_TARGET_RED:   cfg.target_red   <= pwdata[7:0];
        ctmo_pkg::REG_TARGET_GREEN: cfg.target_green <= pwdata[7:0];
        ctmo_pkg::REG_TARGET_BLUE:  cfg.target_blue  <= pwdata[7:0];
        ctmo_pkg::REG_TARGET_ALPHA: cfg.target_alpha <= pwdata[7:0];
        ctmo_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[ctmo_pkg::SIZE_W-1:0];
        ctmo_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[ctmo_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ctmo_pkg::REG_THRESHOLD:    prdata = ctmo_pkg::DATA_W'(cfg.threshold);
      ctmo_pkg::REG_TARGET_RED:   prdata = ctmo_pkg::DATA_W'(cfg.target_red);
      ctmo_pkg::REG_TARGET_GREEN: prdata = ctmo_pkg::DATA_W'(cfg.target_green);
      ctmo_pkg::REG_TARGET_BLUE:  prdata = ctmo_pkg::DATA_W'(cfg.target_blue);
      ctmo_pkg::REG_TARGET_ALPHA: prdata = ctmo_pkg::DATA_W'(cfg.target_alpha);
      ctmo_pkg::REG_IMAGE_WIDTH:  prdata = ctmo_pkg::DATA_W'(cfg.image_width);
      ctmo_pkg::REG_IMAGE_HEIGHT: prdata = ctmo_pkg::DATA_W'(cfg.image_height);
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/ctmo_row_mem.sv
// ----------------------------------------------------------------------------
// ctmo_row_mem
// One-bit line memory with the mask of the row above, registered read.
// ----------------------------------------------------------------------------
module ctmo_row_mem #(
  parameter int DEPTH = ctmo_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a read of the entry being written returns the new bit (one-pixel rows)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// File: hw/rtl/ctmo_emit.sv
// ----------------------------------------------------------------------------
// ctmo_emit
// Holds one classified pixel, sending one result beat per cycle while ready.
// ----------------------------------------------------------------------------
module ctmo_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  ctmo_pkg::desc_t     load_desc,
  output logic                result_valid,
  input  logic                result_ready,
  output ctmo_pkg::result_t   result
);

  ctmo_pkg::desc_t                 d;
  logic                            d_valid;
  logic [ctmo_pkg::SLOT_W-1:0]     sel;
  logic [ctmo_pkg::NUM_SLOTS-1:0]  rest;
  logic                            take;
  logic                            last;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = ctmo_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (d.pend[i]) begin
        sel = ctmo_pkg::SLOT_W'(i);
      end
    end
  end

  assign rest       = d.pend & ~(ctmo_pkg::NUM_SLOTS'(1) << sel);
  assign last       = (rest == '0);
  assign take       = d_valid && result_ready;
  assign load_ready = !d_valid || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (load_valid && load_ready) begin
      d_valid <= 1'b1;
    end else if (take && last) begin
      d_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      d <= load_desc;
    end else if (take) begin
      d.pend <= rest;
    end
  end

  assign result_valid = d_valid;

  always_comb begin
    result       = '0;
    result.pos_x = d.pos_x;
    result.pos_y = d.pos_y;
    result.last  = last;
    case (sel)
      ctmo_pkg::SLOT_MASK: begin
        result.kind    = ctmo_pkg::KIND_MASK;
        result.matched = d.matched;
      end
      ctmo_pkg::SLOT_PREV_RIGHT: begin
        result.kind    = ctmo_pkg::KIND_EDGE;
        result.matched = 1'b1;
        result.side    = ctmo_pkg::SIDE_RIGHT;
        result.pos_x   = d.pos_x - 10'd1;
      end
      ctmo_pkg::SLOT_ABOVE_BOT: begin
        result.kind    = ctmo_pkg::KIND_EDGE;
        result.matched = 1'b1;
        result.side    = ctmo_pkg::SIDE_BOTTOM;
        result.pos_y   = d.pos_y - 10'd1;
      end
      ctmo_pkg::SLOT_TOP: begin
        result.kind    = ctmo_pkg::KIND_EDGE;
        result.matched = 1'b1;
        result.side    = ctmo_pkg::SIDE_TOP;
      end
      ctmo_pkg::SLOT_RIGHT: begin
        result.kind    = ctmo_pkg::KIND_EDGE;
        result.matched = 1'b1;
        result.side    = ctmo_pkg::SIDE_RIGHT;
      end
      ctmo_pkg::SLOT_BOTTOM: begin
        result.kind    = ctmo_pkg::KIND_EDGE;
        result.matched = 1'b1;
        result.side    = ctmo_pkg::SIDE_BOTTOM;
      end
      ctmo_pkg::SLOT_LEFT: begin
        result.kind    = ctmo_pkg::KIND_EDGE;
        result.matched = 1'b1;
        result.side    = ctmo_pkg::SIDE_LEFT;
      end
      ctmo_pkg::SLOT_SUMMARY: begin
        result.kind       = ctmo_pkg::KIND_SUMMARY;
        result.found      = d.found;
        result.box_x_min  = d.box_x_min;
        result.box_y_min  = d.box_y_min;
        result.box_width  = d.box_width;
        result.box_height = d.box_height;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/color_threshold_mask_outline_core.sv
// ----------------------------------------------------------------------------
// color_threshold_mask_outline_core
// Color-key threshold mask with outline edges and bounding box per image.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per cycle while results keep
// draining. Each pixel yields one to six result beats (mask bit, decided
// boundary edges, and the summary after an image's last pixel), and the
// result port delivers one beat per cycle while result_ready is high, so a
// pixel holds the block until all of its results have been taken. The pixel
// is registered in the classify stage and then loaded into the emitter,
// which drives its first result out from there. The mask of the
// row above lives in a one-bit line memory of MAX_WIDTH entries, read when a
// pixel is accepted and written when it is classified; it needs no clearing
// after reset since the first row never consults it.
module color_threshold_mask_outline_core #(
  parameter int MAX_WIDTH  = ctmo_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ctmo_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctmo_pkg::ADDR_W-1:0] paddr,
  input  logic [ctmo_pkg::DATA_W-1:0] pwdata,
  output logic [ctmo_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  ctmo_pkg::pixel_t            pixel,
  output logic                        result_valid,
  input  logic                        result_ready,
  output ctmo_pkg::result_t           result
);

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int WB = ($clog2(MAX_WIDTH + 1) > ctmo_pkg::SIZE_W) ?
                      $clog2(MAX_WIDTH + 1) : ctmo_pkg::SIZE_W;
  localparam int HB = ($clog2(MAX_HEIGHT + 1) > ctmo_pkg::SIZE_W) ?
                      $clog2(MAX_HEIGHT + 1) : ctmo_pkg::SIZE_W;

  function automatic logic near(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] thr);
    logic [7:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff <= thr;
  endfunction

  ctmo_pkg::cfg_t cfg;

  ctmo_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective image size
  logic [WB-1:0] w_raw, w_lim, w_m1;
  logic [HB-1:0] h_raw, h_lim, h_m1;

  assign w_raw = WB'(cfg.image_width);
  assign h_raw = HB'(cfg.image_height);
  assign w_lim = (w_raw == '0) ? WB'(1) :
                 ((w_raw > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : w_raw);
  assign h_lim = (h_raw == '0) ? HB'(1) :
                 ((h_raw > HB'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : h_raw);
  assign w_m1  = w_lim - WB'(1);
  assign h_m1  = h_lim - HB'(1);

  // raster position of the next pixel
  logic [XB-1:0] column_count;
  logic [YB-1:0] row_count;
  logic          accept;
  logic          row_end_now, y_last_now, img_end_now;

  assign accept      = pixel_valid && pixel_ready;
  assign row_end_now = WB'(column_count) >= w_m1;
  assign y_last_now  = HB'(row_count) >= h_m1;
  assign img_end_now = row_end_now && y_last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end_now) begin
        column_count <= '0;
        row_count    <= img_end_now ? '0 : row_count + YB'(1);
      end else begin
        column_count <= column_count + XB'(1);
      end
    end
  end

  // classify stage
  logic             s1_valid;
  ctmo_pkg::pixel_t s1_pix;
  logic [XB-1:0]    s1_x;
  logic [YB-1:0]    s1_y;
  logic             s1_row_end, s1_y_last, s1_img_end;
  logic             s1_fire;
  logic             emit_ready;
  logic             above_bit;

  assign s1_fire     = s1_valid && emit_ready;
  assign pixel_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix     <= pixel;
      s1_x       <= column_count;
      s1_y       <= row_count;
      s1_row_end <= row_end_now;
      s1_y_last  <= y_last_now;
      s1_img_end <= img_end_now;
    end
  end

  logic m;

  assign m = near(s1_pix.pixel_red,   cfg.target_red,   cfg.threshold)
          && near(s1_pix.pixel_green, cfg.target_green, cfg.threshold)
          && near(s1_pix.pixel_blue,  cfg.target_blue,  cfg.threshold)
          && near(s1_pix.pixel_alpha, cfg.target_alpha, cfg.threshold);

  ctmo_row_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (XB)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (above_bit),
    .wr_en   (s1_fire),
    .wr_addr (s1_x),
    .wr_data (m)
  );

  logic left_match;
  logic x0, y0, above;

  assign x0    = (s1_x == '0);
  assign y0    = (s1_y == '0);
  assign above = !y0 && above_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_match <= 1'b0;
    end else if (s1_fire) begin
      left_match <= s1_row_end ? 1'b0 : m;
    end
  end

  // bounding box
  logic [XB-1:0] min_column, max_column, min_column_next, max_column_next;
  logic [YB-1:0] min_row, max_row, min_row_next, max_row_next;
  logic          any_found, any_found_next;

  always_comb begin
    min_column_next = min_column;
    max_column_next = max_column;
    min_row_next    = min_row;
    max_row_next    = max_row;
    any_found_next  = any_found;
    if (m) begin
      any_found_next = 1'b1;
      if (!any_found) begin
        min_column_next = s1_x;
        max_column_next = s1_x;
        min_row_next    = s1_y;
        max_row_next    = s1_y;
      end else begin
        if (s1_x < min_column) min_column_next = s1_x;
        if (s1_x > max_column) max_column_next = s1_x;
        if (s1_y < min_row)    min_row_next    = s1_y;
        if (s1_y > max_row)    max_row_next    = s1_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_column <= '0;
      max_column <= '0;
      min_row    <= '0;
      max_row    <= '0;
      any_found  <= 1'b0;
    end else if (s1_fire) begin
      if (s1_img_end) begin
        min_column <= '0;
        max_column <= '0;
        min_row    <= '0;
        max_row    <= '0;
        any_found  <= 1'b0;
      end else begin
        min_column <= min_column_next;
        max_column <= max_column_next;
        min_row    <= min_row_next;
        max_row    <= max_row_next;
        any_found  <= any_found_next;
      end
    end
  end

  ctmo_pkg::desc_t desc;

  always_comb begin
    desc         = '0;
    desc.pos_x   = 10'(s1_x);
    desc.pos_y   = 10'(s1_y);
    desc.matched = m;
    desc.pend[ctmo_pkg::SLOT_MASK]       = 1'b1;
    desc.pend[ctmo_pkg::SLOT_PREV_RIGHT] = !x0 && left_match && !m;
    desc.pend[ctmo_pkg::SLOT_ABOVE_BOT]  = above && !m;
    desc.pend[ctmo_pkg::SLOT_TOP]        = m && (y0 || !above);
    desc.pend[ctmo_pkg::SLOT_RIGHT]      = m && s1_row_end;
    desc.pend[ctmo_pkg::SLOT_BOTTOM]     = m && s1_y_last;
    desc.pend[ctmo_pkg::SLOT_LEFT]       = m && (x0 || !left_match);
    desc.pend[ctmo_pkg::SLOT_SUMMARY]    = s1_img_end;
    if (any_found_next) begin
      desc.found      = 1'b1;
      desc.box_x_min  = 10'(min_column_next);
      desc.box_y_min  = 10'(min_row_next);
      desc.box_width  = 11'(max_column_next) - 11'(min_column_next) + 11'd1;
      desc.box_height = 11'(max_row_next) - 11'(min_row_next) + 11'd1;
    end
  end

  ctmo_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (s1_valid),
    .load_ready   (emit_ready),
    .load_desc    (desc),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTH
  // the summary closes the burst of the image's last pixel
  a_summary_last : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == ctmo_pkg::KIND_SUMMARY |-> result.last)
    else $error("summary beat without last");

  // an edge always belongs to a matching pixel
  a_edge_matched : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == ctmo_pkg::KIND_EDGE |-> result.matched)
    else $error("edge beat with matched low");

  // a stalled classify stage keeps its pixel position
  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && s1_x == $past(s1_x) && s1_y == $past(s1_y))
    else $error("classify stage lost its pixel while stalled");
`endif

endmodule
